### design/lcps_pkg.sv
package lcps_pkg;

  // widths fixed by the field list
  localparam int WORD_W   = 32;
  localparam int CTL_W    = 8;
  localparam int OFS_W    = 7;
  localparam int STAT_W   = 2;
  localparam int PERIOD_W = 15;
  localparam int FRAMES_W = 7;
  localparam int PHASE_W  = 16;
  localparam int IDX_W    = 3;
  localparam int CNT_W    = 7;
  localparam int REM_W    = 6;
  localparam int STEP_W   = 4;

  // build-time defaults
  localparam int MAX_FRAMES_DEF       = 64;
  localparam int READ_FRAME_LIMIT_DEF = 12;
  localparam int RESULT_CAP           = 64;

  // register indexes
  localparam logic [IDX_W-1:0] REG_PERIOD  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAMES  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CFG_BASE = 3'd2;
  localparam logic [IDX_W-1:0] REG_STBY_NOP = 3'd3;
  localparam logic [IDX_W-1:0] REG_BTEL_NOP = 3'd4;
  localparam logic [IDX_W-1:0] REG_CHECK    = 3'd5;

  // reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 15'd1000;
  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 7'd4;
  localparam logic [PHASE_W-1:0]  PHASE_RESET  = 16'(-$signed({1'b0, PERIOD_RESET}));

  localparam logic [CTL_W-1:0] CTL_CLR_MASK = 8'hFE;
  localparam logic [CTL_W-1:0] CTL_SET_MASK = 8'h01;

  // status codes
  localparam logic [STAT_W-1:0] STATUS_NONE    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_ENABLED = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_SKIPPED = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_FIRED   = 2'd3;

  // program addresses
  localparam logic [STEP_W-1:0] STEP_FETCH   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CFG_ON  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_PAD     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CFG_OFF = 4'd3;
  localparam logic [STEP_W-1:0] STEP_RD_CHK  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_RD_SB1  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_RD_SB2  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RD_BT   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_REPORT  = 4'd8;

  typedef enum logic [2:0] {
    SRC_ZERO, SRC_CFG, SRC_STBY, SRC_BTEL, SRC_CHECK
  } word_src_t;

  typedef enum logic [1:0] {
    CTL_KEEP, CTL_SET, CTL_CLR
  } ctl_op_t;

  typedef enum logic [1:0] {
    ST_NONE, ST_ENABLED, ST_REPORT
  } st_sel_t;

  typedef enum logic {
    JMP_SEQ, JMP_N3
  } jmp_cond_t;

  // one control word of the program
  typedef struct packed {
    logic              is_fetch;
    word_src_t         src;
    logic              wvalid;
    logic              cvalid;
    ctl_op_t           ctl_op;
    st_sel_t           st_sel;
    jmp_cond_t         cond;
    logic [STEP_W-1:0] next;
    logic [STEP_W-1:0] alt;
  } ctrl_word_t;

  // sequencer to datapath
  typedef struct packed {
    logic             take;
    logic             fire;
    word_src_t        src;
    logic             wvalid;
    logic             cvalid;
    ctl_op_t          ctl_op;
    st_sel_t          st_sel;
    logic [OFS_W-1:0] offset;
    logic             last;
  } emit_cmd_t;

  // datapath to sequencer
  typedef struct packed {
    logic             ph0;
    logic             ph1;
    logic             ph2;
    logic             ph4;
    logic [CNT_W-1:0] cfg_cnt;
    logic [CNT_W-1:0] rd_cnt;
    logic             n_is3;
    logic             out_busy;
  } dp_stat_t;

  function automatic ctrl_word_t mk(input logic is_fetch, input word_src_t src,
                                    input logic wvalid, input logic cvalid,
                                    input ctl_op_t ctl_op, input st_sel_t st_sel,
                                    input jmp_cond_t cond,
                                    input logic [STEP_W-1:0] next,
                                    input logic [STEP_W-1:0] alt);
    ctrl_word_t w;
    w.is_fetch = is_fetch;
    w.src      = src;
    w.wvalid   = wvalid;
    w.cvalid   = cvalid;
    w.ctl_op   = ctl_op;
    w.st_sel   = st_sel;
    w.cond     = cond;
    w.next     = next;
    w.alt      = alt;
    return w;
  endfunction

  // program rom
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    unique case (step)
      STEP_CFG_ON:  w = mk(1'b0, SRC_CFG, 1'b1, 1'b1, CTL_SET, ST_ENABLED, JMP_SEQ,
                           STEP_PAD, STEP_PAD);
      STEP_PAD:     w = mk(1'b0, SRC_STBY, 1'b1, 1'b0, CTL_KEEP, ST_NONE, JMP_SEQ,
                           STEP_PAD, STEP_PAD);
      STEP_CFG_OFF: w = mk(1'b0, SRC_CFG, 1'b1, 1'b1, CTL_CLR, ST_NONE, JMP_SEQ,
                           STEP_PAD, STEP_PAD);
      STEP_RD_CHK:  w = mk(1'b0, SRC_CHECK, 1'b1, 1'b0, CTL_KEEP, ST_NONE, JMP_N3,
                           STEP_RD_BT, STEP_RD_SB1);
      STEP_RD_SB1:  w = mk(1'b0, SRC_STBY, 1'b1, 1'b0, CTL_KEEP, ST_NONE, JMP_SEQ,
                           STEP_RD_SB2, STEP_RD_SB2);
      STEP_RD_SB2:  w = mk(1'b0, SRC_STBY, 1'b1, 1'b0, CTL_KEEP, ST_NONE, JMP_SEQ,
                           STEP_RD_BT, STEP_RD_BT);
      STEP_RD_BT:   w = mk(1'b0, SRC_BTEL, 1'b1, 1'b0, CTL_KEEP, ST_NONE, JMP_SEQ,
                           STEP_RD_BT, STEP_RD_BT);
      STEP_REPORT:  w = mk(1'b0, SRC_ZERO, 1'b0, 1'b0, CTL_KEEP, ST_REPORT, JMP_SEQ,
                           STEP_FETCH, STEP_FETCH);
      default:      w = mk(1'b1, SRC_ZERO, 1'b0, 1'b0, CTL_KEEP, ST_NONE, JMP_SEQ,
                           STEP_FETCH, STEP_FETCH);
    endcase
    return w;
  endfunction

endpackage

### design/link_check_pcm_sequencer_top.sv
// output path: the first word of a tick passes the program counter, then the output register
// throughput: one word per cycle from the step counter while out_ready holds; the sequencer
//   takes no new tick until a tick's last word is issued, and a tick with no words leaves it ready
// reset: rst_n low clears the output valid and program counter, loads the register defaults
//   and sets the phase counter to minus the default period

module link_check_pcm_sequencer_top #(
  parameter int MAX_FRAMES       = lcps_pkg::MAX_FRAMES_DEF,
  parameter int READ_FRAME_LIMIT = lcps_pkg::READ_FRAME_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lcps_pkg::IDX_W-1:0]   cfg_index,
  input  logic [lcps_pkg::WORD_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lcps_pkg::CTL_W-1:0]   in_control_now,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lcps_pkg::WORD_W-1:0]  out_pcm_word,
  output logic                         out_word_valid,
  output logic [lcps_pkg::OFS_W-1:0]   out_word_offset,
  output logic                         out_control_valid,
  output logic [lcps_pkg::CTL_W-1:0]   out_control_new,
  output logic [lcps_pkg::STAT_W-1:0]  out_status_code,
  output logic                         out_last
);

  lcps_pkg::emit_cmd_t cmd;
  lcps_pkg::dp_stat_t  stat;

  // program sequencer
  lcps_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // registers, phase counter and word selection
  lcps_datapath #(
    .MAX_FRAMES       (MAX_FRAMES),
    .READ_FRAME_LIMIT (READ_FRAME_LIMIT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_control_now    (in_control_now),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pcm_word      (out_pcm_word),
    .out_word_valid    (out_word_valid),
    .out_word_offset   (out_word_offset),
    .out_control_valid (out_control_valid),
    .out_control_new   (out_control_new),
    .out_status_code   (out_status_code),
    .out_last          (out_last)
  );

endmodule

### design/lcps_sequencer.sv
module lcps_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lcps_pkg::dp_stat_t   stat,
  output lcps_pkg::emit_cmd_t  cmd
);

  logic [lcps_pkg::STEP_W-1:0] pc_r, pc_nxt;
  logic [lcps_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [lcps_pkg::REM_W-1:0]  k_r, k_nxt;
  lcps_pkg::ctrl_word_t        cw;
  logic                        fire;

  assign cw       = lcps_pkg::ucode(pc_r);
  assign in_ready = cw.is_fetch;
  assign fire     = !cw.is_fetch && !stat.out_busy;

  // emit command for the datapath
  always_comb begin
    cmd.take   = cw.is_fetch && in_valid;
    cmd.fire   = fire;
    cmd.src    = cw.src;
    cmd.wvalid = cw.wvalid;
    cmd.cvalid = cw.cvalid;
    cmd.ctl_op = cw.ctl_op;
    cmd.st_sel = cw.st_sel;
    cmd.offset = {1'b0, k_r};
    cmd.last   = (rem_r == '0);
  end

  // step counter, dispatch on phase and loop sequencing
  always_comb begin
    pc_nxt  = pc_r;
    rem_nxt = rem_r;
    k_nxt   = k_r;
    if (cw.is_fetch) begin
      if (in_valid) begin
        k_nxt = '0;
        if (stat.ph0) begin
          pc_nxt  = lcps_pkg::STEP_CFG_ON;
          rem_nxt = lcps_pkg::REM_W'(stat.cfg_cnt - 1'b1);
        end else if (stat.ph2) begin
          pc_nxt  = lcps_pkg::STEP_CFG_OFF;
          rem_nxt = lcps_pkg::REM_W'(stat.cfg_cnt - 1'b1);
        end else if (stat.ph1 && stat.rd_cnt != '0) begin
          pc_nxt  = lcps_pkg::STEP_RD_CHK;
          rem_nxt = lcps_pkg::REM_W'(stat.rd_cnt - 1'b1);
        end else if (stat.ph4) begin
          pc_nxt  = lcps_pkg::STEP_REPORT;
          rem_nxt = '0;
        end
      end
    end else if (fire) begin
      rem_nxt = rem_r - 1'b1;
      k_nxt   = k_r + 1'b1;
      if (rem_r == '0) begin
        pc_nxt = lcps_pkg::STEP_FETCH;
      end else if (cw.cond == lcps_pkg::JMP_N3 && stat.n_is3) begin
        pc_nxt = cw.alt;
      end else begin
        pc_nxt = cw.next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= lcps_pkg::STEP_FETCH;
      rem_r <= '0;
      k_r   <= '0;
    end else begin
      pc_r  <= pc_nxt;
      rem_r <= rem_nxt;
      k_r   <= k_nxt;
    end
  end

endmodule

### design/lcps_datapath.sv
module lcps_datapath #(
  parameter int MAX_FRAMES       = lcps_pkg::MAX_FRAMES_DEF,
  parameter int READ_FRAME_LIMIT = lcps_pkg::READ_FRAME_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lcps_pkg::IDX_W-1:0]       cfg_index,
  input  logic [lcps_pkg::WORD_W-1:0]      cfg_data,
  input  logic [lcps_pkg::CTL_W-1:0]       in_control_now,
  input  lcps_pkg::emit_cmd_t              cmd,
  output lcps_pkg::dp_stat_t               stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lcps_pkg::WORD_W-1:0]      out_pcm_word,
  output logic                             out_word_valid,
  output logic [lcps_pkg::OFS_W-1:0]       out_word_offset,
  output logic                             out_control_valid,
  output logic [lcps_pkg::CTL_W-1:0]       out_control_new,
  output logic [lcps_pkg::STAT_W-1:0]      out_status_code,
  output logic                             out_last
);

  localparam logic [lcps_pkg::FRAMES_W-1:0] MAX_N   = lcps_pkg::FRAMES_W'(MAX_FRAMES);
  localparam logic [lcps_pkg::FRAMES_W-1:0] LIMIT_N = lcps_pkg::FRAMES_W'(READ_FRAME_LIMIT);
  localparam logic [lcps_pkg::CNT_W-1:0]    CAP     = lcps_pkg::CNT_W'(lcps_pkg::RESULT_CAP);

  logic [lcps_pkg::PERIOD_W-1:0] period_r;
  logic [lcps_pkg::FRAMES_W-1:0] frames_r;
  logic [lcps_pkg::WORD_W-1:0]   cfg_base_r, stby_r, btel_r, check_r;
  logic [lcps_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [lcps_pkg::CTL_W-1:0]    ctl_r;

  logic                          out_valid_r;
  logic [lcps_pkg::WORD_W-1:0]   word_r;
  logic                          wvalid_r, cvalid_r, last_r;
  logic [lcps_pkg::OFS_W-1:0]    ofs_r;
  logic [lcps_pkg::CTL_W-1:0]    cnew_r;
  logic [lcps_pkg::STAT_W-1:0]   status_r;

  logic [lcps_pkg::FRAMES_W-1:0] n_sat;
  logic [lcps_pkg::CNT_W-1:0]    cfg_cnt, rd_cnt, rd_raw;
  logic [lcps_pkg::CTL_W-1:0]    ctl_mod;
  logic [lcps_pkg::WORD_W-1:0]   word_sel;
  logic [lcps_pkg::STAT_W-1:0]   status_sel;
  logic                          n_over;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= lcps_pkg::PERIOD_RESET;
      frames_r   <= lcps_pkg::FRAMES_RESET;
      cfg_base_r <= '0;
      stby_r     <= '0;
      btel_r     <= '0;
      check_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lcps_pkg::REG_PERIOD:   period_r   <= cfg_data[lcps_pkg::PERIOD_W-1:0];
        lcps_pkg::REG_FRAMES:   frames_r   <= cfg_data[lcps_pkg::FRAMES_W-1:0];
        lcps_pkg::REG_CFG_BASE: cfg_base_r <= cfg_data;
        lcps_pkg::REG_STBY_NOP: stby_r     <= cfg_data;
        lcps_pkg::REG_BTEL_NOP: btel_r     <= cfg_data;
        lcps_pkg::REG_CHECK:    check_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase steps up per tick to period, then wraps to zero; reset loads minus default period
  always_comb begin
    if ($signed({phase_r[lcps_pkg::PHASE_W-1], phase_r}) < $signed({2'b00, period_r})) begin
      phase_nxt = phase_r + 1'b1;
    end else begin
      phase_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lcps_pkg::PHASE_RESET;
    end else if (cmd.take) begin
      phase_r <= phase_nxt;
    end
  end

  // control value of the tick
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ctl_r <= in_control_now;
    end
  end

  // run lengths from the frame count
  always_comb begin
    n_sat   = (frames_r > MAX_N) ? MAX_N : frames_r;
    cfg_cnt = (n_sat == '0) ? lcps_pkg::CNT_W'(1) : n_sat;
    if (cfg_cnt > CAP) cfg_cnt = CAP;
    n_over = (frames_r > LIMIT_N);
    case (frames_r)
      7'd1:    rd_raw = 7'd4;
      7'd2:    rd_raw = 7'd8;
      7'd3:    rd_raw = 7'd9;
      7'd0:    rd_raw = 7'd1;
      default: rd_raw = n_over ? 7'd0 : {frames_r[lcps_pkg::FRAMES_W-2:0], 1'b0};
    endcase
    rd_cnt = (rd_raw > CAP) ? CAP : rd_raw;
  end

  always_comb begin
    stat.ph0      = (phase_r == 16'd0);
    stat.ph1      = (phase_r == 16'd1);
    stat.ph2      = (phase_r == 16'd2);
    stat.ph4      = (phase_r == 16'd4);
    stat.cfg_cnt  = cfg_cnt;
    stat.rd_cnt   = rd_cnt;
    stat.n_is3    = (frames_r == 7'd3);
    stat.out_busy = out_valid_r && !out_ready;
  end

  // word and status selection
  always_comb begin
    case (cmd.ctl_op)
      lcps_pkg::CTL_SET: ctl_mod = ctl_r | lcps_pkg::CTL_SET_MASK;
      lcps_pkg::CTL_CLR: ctl_mod = ctl_r & lcps_pkg::CTL_CLR_MASK;
      default:           ctl_mod = ctl_r;
    endcase
    case (cmd.src)
      lcps_pkg::SRC_CFG:   word_sel = {{(lcps_pkg::WORD_W-lcps_pkg::CTL_W){1'b0}}, ctl_mod}
                                      | cfg_base_r;
      lcps_pkg::SRC_STBY:  word_sel = stby_r;
      lcps_pkg::SRC_BTEL:  word_sel = btel_r;
      lcps_pkg::SRC_CHECK: word_sel = check_r;
      default:             word_sel = '0;
    endcase
    case (cmd.st_sel)
      lcps_pkg::ST_ENABLED: status_sel = lcps_pkg::STATUS_ENABLED;
      lcps_pkg::ST_REPORT:  status_sel = n_over ? lcps_pkg::STATUS_SKIPPED
                                                : lcps_pkg::STATUS_FIRED;
      default:              status_sel = lcps_pkg::STATUS_NONE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      word_r   <= word_sel;
      wvalid_r <= cmd.wvalid;
      ofs_r    <= cmd.wvalid ? cmd.offset : '0;
      cvalid_r <= cmd.cvalid;
      cnew_r   <= cmd.cvalid ? ctl_mod : '0;
      status_r <= status_sel;
      last_r   <= cmd.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pcm_word      = word_r;
  assign out_word_valid    = wvalid_r;
  assign out_word_offset   = ofs_r;
  assign out_control_valid = cvalid_r;
  assign out_control_new   = cnew_r;
  assign out_status_code   = status_r;
  assign out_last          = last_r;

endmodule

### test/tb.sv
module tb;
  import lcps_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 5;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_TICKS  = 480;
  localparam int IDLE_PCT      = 24;
  localparam int REPORT_LIMIT  = 10;
  localparam int WARMUP_TICKS  = 1000;
  // index past the last register, must be ignored
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

  // one result beat, in port order
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              wvalid;
    logic [OFS_W-1:0]  offset;
    logic              cvalid;
    logic [CTL_W-1:0]  cnew;
    logic [STAT_W-1:0] status;
    logic              is_last;
  } pcm_beat_t;

  typedef enum logic [1:0] {
    ROW_CFG, ROW_PREDICT, ROW_TYPED
  } row_kind_t;

  // one line of the directed plan
  typedef struct packed {
    row_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] data;
    logic [CTL_W-1:0]  ctl;
    int                reps;
    int                n_exp;
    pcm_beat_t         beat;
  } plan_row_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                cfg_we         = 1'b0;
  logic [IDX_W-1:0]    cfg_index      = '0;
  logic [WORD_W-1:0]   cfg_data       = '0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [CTL_W-1:0]    in_control_now = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [WORD_W-1:0]   out_pcm_word;
  logic                out_word_valid;
  logic [OFS_W-1:0]    out_word_offset;
  logic                out_control_valid;
  logic [CTL_W-1:0]    out_control_new;
  logic [STAT_W-1:0]   out_status_code;
  logic                out_last;

  // shadow of the sequencer state and registers
  logic signed [PHASE_W-1:0] phase_q;
  logic [PERIOD_W-1:0]       period_q;
  logic [FRAMES_W-1:0]       frames_q;
  logic [WORD_W-1:0]         base_q;
  logic [WORD_W-1:0]         stby_q;
  logic [WORD_W-1:0]         btel_q;
  logic [WORD_W-1:0]         check_q;

  pcm_beat_t pending_words[$];
  pcm_beat_t tick_words[$];
  plan_row_t plan[$];
  int        mismatches  = 0;
  int        cycle_count = 0;
  bit        steady      = 1'b0;

  link_check_pcm_sequencer_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_control_now    (in_control_now),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pcm_word      (out_pcm_word),
    .out_word_valid    (out_word_valid),
    .out_word_offset   (out_word_offset),
    .out_control_valid (out_control_valid),
    .out_control_new   (out_control_new),
    .out_status_code   (out_status_code),
    .out_last          (out_last)
  );

  always #HALF_PERIOD clk = ~clk;

  // append one word, offset is its position in the tick
  function automatic void push_word(input logic [WORD_W-1:0] word, input logic wvalid,
                                    input logic cvalid, input logic [CTL_W-1:0] cnew,
                                    input logic [STAT_W-1:0] status);
    pcm_beat_t b;
    b.word    = word;
    b.wvalid  = wvalid;
    b.offset  = OFS_W'(tick_words.size());
    b.cvalid  = cvalid;
    b.cnew    = cnew;
    b.status  = status;
    b.is_last = 1'b0;
    tick_words.push_back(b);
  endfunction

  // config word then standby padding, frame count saturated
  function automatic void emit_switch(input logic [CTL_W-1:0] ctl,
                                      input logic [STAT_W-1:0] status);
    int n;
    n = (int'(frames_q) > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : int'(frames_q);
    push_word(ctl | base_q, 1'b1, 1'b1, ctl, status);
    for (int k = 1; k < n; k++) push_word(stby_q, 1'b1, 1'b0, '0, STATUS_NONE);
  endfunction

  // check word then backtel nops, n of three pads with two standby words
  function automatic void emit_read();
    int n;
    int count;
    n = int'(frames_q);
    if (n > READ_FRAME_LIMIT_DEF) count = 0;
    else if (n == 0) count = 1;
    else if (n == 1) count = 4;
    else if (n == 2) count = 8;
    else if (n == 3) count = 9;
    else count = 2 * n;
    for (int k = 0; k < count; k++) begin
      if (k == 0) push_word(check_q, 1'b1, 1'b0, '0, STATUS_NONE);
      else if (n == 3 && k <= 2) push_word(stby_q, 1'b1, 1'b0, '0, STATUS_NONE);
      else push_word(btel_q, 1'b1, 1'b0, '0, STATUS_NONE);
    end
  endfunction

  // words caused by one tick, then step the phase counter
  function automatic void predict_tick(input logic [CTL_W-1:0] ctl);
    pcm_beat_t b;
    tick_words.delete();
    if (phase_q == 0) emit_switch(ctl | CTL_SET_MASK, STATUS_ENABLED);
    else if (phase_q == 1) emit_read();
    else if (phase_q == 2) emit_switch(ctl & CTL_CLR_MASK, STATUS_NONE);
    else if (phase_q == 4)
      push_word('0, 1'b0, 1'b0, '0,
                (int'(frames_q) > READ_FRAME_LIMIT_DEF) ? STATUS_SKIPPED : STATUS_FIRED);
    if (tick_words.size() > 0) begin
      b = tick_words.pop_back();
      b.is_last = 1'b1;
      tick_words.push_back(b);
    end
    if (phase_q < $signed({1'b0, period_q})) phase_q = phase_q + 16'sd1;
    else phase_q = '0;
  endfunction

  function automatic plan_row_t cfg_row(input logic [IDX_W-1:0] idx,
                                        input logic [WORD_W-1:0] data);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t predict_row(input logic [CTL_W-1:0] ctl, input int reps);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_PREDICT;
    r.ctl  = ctl;
    r.reps = reps;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic [CTL_W-1:0] ctl, input int reps,
                                          input int n_exp, input pcm_beat_t beat);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_TYPED;
    r.ctl   = ctl;
    r.reps  = reps;
    r.n_exp = n_exp;
    r.beat  = beat;
    return r;
  endfunction

  // a tick whose only beat is also its last
  function automatic pcm_beat_t one_beat(input logic [WORD_W-1:0] word, input logic wvalid,
                                         input logic cvalid, input logic [CTL_W-1:0] cnew,
                                         input logic [STAT_W-1:0] status);
    pcm_beat_t b;
    b.word    = word;
    b.wvalid  = wvalid;
    b.offset  = '0;
    b.cvalid  = cvalid;
    b.cnew    = cnew;
    b.status  = status;
    b.is_last = 1'b1;
    return b;
  endfunction

  // hold the sender until every expected word is out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PERIOD:   period_q = data[PERIOD_W-1:0];
      REG_FRAMES:   frames_q = data[FRAMES_W-1:0];
      REG_CFG_BASE: base_q   = data;
      REG_STBY_NOP: stby_q   = data;
      REG_BTEL_NOP: btel_q   = data;
      REG_CHECK:    check_q  = data;
      default: ;
    endcase
  endtask

  // one tick beat with random gaps, prediction taken at acceptance
  task automatic send_tick(input logic [CTL_W-1:0] ctl);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_control_now <= ctl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(ctl);
  endtask

  task automatic send_predicted(input logic [CTL_W-1:0] ctl);
    send_tick(ctl);
    foreach (tick_words[k]) pending_words.push_back(tick_words[k]);
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // compare each accepted word beat with the oldest expectation
  always @(posedge clk) begin
    pcm_beat_t got;
    pcm_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_pcm_word, out_word_valid, out_word_offset, out_control_valid,
             out_control_new, out_status_code, out_last};
      if (pending_words.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected beat: word=%h wv=%b ofs=%0d cv=%b cnew=%h st=%0d last=%b",
                   got.word, got.wvalid, got.offset, got.cvalid, got.cnew, got.status,
                   got.is_last);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (got.word !== want.word || got.wvalid !== want.wvalid ||
            got.offset !== want.offset || got.cvalid !== want.cvalid ||
            got.cnew !== want.cnew || got.status !== want.status ||
            got.is_last !== want.is_last) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("beat mismatch exp: word=%h wv=%b ofs=%0d cv=%b cnew=%h st=%0d last=%b",
                     want.word, want.wvalid, want.offset, want.cvalid, want.cnew,
                     want.status, want.is_last);
            $display("               got: word=%h wv=%b ofs=%0d cv=%b cnew=%h st=%0d last=%b",
                     got.word, got.wvalid, got.offset, got.cvalid, got.cnew,
                     got.status, got.is_last);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("link_check_pcm_sequencer_top test failed");
      $finish;
    end
  end

  initial begin
    int round;
    int burst;
    int roll;
    int ticks_sent;
    logic [WORD_W-1:0] value;

    phase_q  = PHASE_RESET;
    period_q = PERIOD_RESET;
    frames_q = FRAMES_RESET;
    base_q   = '0;
    stby_q   = '0;
    btel_q   = '0;
    check_q  = '0;

    // walk up from minus the default period, silent until phase zero
    plan.push_back(typed_row(8'hA5, WARMUP_TICKS, 0, '0));
    // first cycle with default registers
    plan.push_back(predict_row(8'h00, 1));
    plan.push_back(predict_row(8'hFF, 2));
    plan.push_back(typed_row(8'h00, 1, 0, '0));
    plan.push_back(typed_row(8'h00, 1, 1, one_beat('0, 1'b0, 1'b0, '0, STATUS_FIRED)));
    // short period, all-ones and alternating words, single frame
    plan.push_back(cfg_row(REG_PERIOD, 32'd5));
    plan.push_back(cfg_row(REG_CFG_BASE, 32'hFFFF_FF00));
    plan.push_back(cfg_row(REG_STBY_NOP, 32'hAAAA_AAAA));
    plan.push_back(cfg_row(REG_BTEL_NOP, 32'h5555_5555));
    plan.push_back(cfg_row(REG_CHECK, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_FRAMES, 32'd1));
    plan.push_back(typed_row(8'h00, 1, 0, '0));
    plan.push_back(typed_row(8'h80, 1, 1,
                             one_beat(32'hFFFF_FF81, 1'b1, 1'b1, 8'h81, STATUS_ENABLED)));
    plan.push_back(predict_row(8'h3C, 1));
    plan.push_back(typed_row(8'h01, 1, 1,
                             one_beat(32'hFFFF_FF00, 1'b1, 1'b1, 8'h00, STATUS_NONE)));
    plan.push_back(typed_row(8'h00, 1, 0, '0));
    plan.push_back(typed_row(8'h00, 1, 1, one_beat('0, 1'b0, 1'b0, '0, STATUS_FIRED)));
    plan.push_back(typed_row(8'h00, 1, 0, '0));
    // zero frames: lone config word, lone check word
    plan.push_back(cfg_row(REG_FRAMES, 32'd0));
    plan.push_back(typed_row(8'hFE, 1, 1,
                             one_beat(32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, STATUS_ENABLED)));
    plan.push_back(typed_row(8'h00, 1, 1,
                             one_beat(32'hFFFF_FFFF, 1'b1, 1'b0, '0, STATUS_NONE)));
    plan.push_back(typed_row(8'hFF, 1, 1,
                             one_beat(32'hFFFF_FFFE, 1'b1, 1'b1, 8'hFE, STATUS_NONE)));
    plan.push_back(typed_row(8'h00, 1, 0, '0));
    plan.push_back(typed_row(8'h00, 1, 1, one_beat('0, 1'b0, 1'b0, '0, STATUS_FIRED)));
    plan.push_back(typed_row(8'h00, 1, 0, '0));
    // largest frame count: saturated switch words, read skipped
    plan.push_back(cfg_row(REG_FRAMES, 32'd127));
    plan.push_back(predict_row(8'h55, 1));
    plan.push_back(typed_row(8'h00, 1, 0, '0));
    plan.push_back(predict_row(8'hAA, 1));
    plan.push_back(typed_row(8'h00, 1, 0, '0));
    plan.push_back(typed_row(8'h00, 1, 1, one_beat('0, 1'b0, 1'b0, '0, STATUS_SKIPPED)));
    // longest period, then period zero below the running counter
    plan.push_back(cfg_row(REG_PERIOD, 32'd32767));
    plan.push_back(typed_row(8'h00, 3, 0, '0));
    plan.push_back(cfg_row(REG_PERIOD, 32'd0));
    plan.push_back(typed_row(8'h00, 1, 0, '0));
    plan.push_back(cfg_row(REG_FRAMES, 32'd3));
    plan.push_back(predict_row(8'h7E, 2));
    plan.push_back(cfg_row(REG_SPARE, 32'hFFFF_FFFF));
    // back to a short period, three-frame read pattern
    plan.push_back(cfg_row(REG_PERIOD, 32'd5));
    plan.push_back(predict_row(8'h81, 2));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed plan
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        for (int r = 0; r < plan[i].reps; r++) begin
          if (plan[i].kind == ROW_PREDICT) begin
            send_predicted(plan[i].ctl);
          end else begin
            send_tick(plan[i].ctl);
            if (plan[i].n_exp != 0) pending_words.push_back(plan[i].beat);
          end
        end
      end
    end

    // random rounds: new settings, then a burst of ticks
    ticks_sent = 0;
    for (round = 0; ticks_sent < RANDOM_TICKS; round++) begin
      steady = (round >= 8 && round < 12);
      roll = $urandom_range(99);
      if (roll < 70) value = $urandom_range(9, 5);
      else if (roll < 85) value = $urandom_range(40, 10);
      else if (roll < 93) value = 0;
      else value = 32767;
      write_reg(REG_PERIOD, value);
      case ($urandom_range(7))
        0: value = 0;
        1: value = 1;
        2: value = 2;
        3: value = 3;
        4: value = $urandom_range(12, 4);
        5: value = $urandom_range(13, 12);
        6: value = $urandom_range(64, 14);
        default: value = $urandom_range(127, 65);
      endcase
      write_reg(REG_FRAMES, value);
      for (int r = REG_CFG_BASE; r <= REG_CHECK; r++)
        if ($urandom_range(1) == 1) write_reg(IDX_W'(r), $urandom());
      burst = $urandom_range(30, 8);
      repeat (burst) begin
        send_predicted(CTL_W'($urandom_range(255)));
        ticks_sent++;
      end
    end
    steady = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0)
      $display("link_check_pcm_sequencer_top test passed");
    else
      $display("link_check_pcm_sequencer_top test failed");
    $finish;
  end

endmodule
